// ===== rtl/core/phist_pkg.sv =====
// Shared types and constants of the pixel histogram block.
`default_nettype none

package phist_pkg;

  // Input word layout (lowest bits first): opcode, pixel_value, bin_index.
  localparam int OPCODE_W    = 2;
  localparam int PIXEL_W     = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_W       = 32;
  localparam int OUT_TDATA_W = 2 * OUT_W;

  localparam logic [PIXEL_W-1:0] PEAK_START_RESET = 8'd20;

  // Output queue holds three words so a new item can enter every cycle while results are taken.
  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_CNT_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_COUNT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } phist_op_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CLEAR = 3'b010,
    ST_SCAN  = 3'b100
  } phist_state_t;

  // Status and memory requests from the sequencer to the datapath.
  typedef struct packed {
    logic busy;
    logic mem_we;
    logic mem_re;
    logic peak_load;
  } phist_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/phist_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module phist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/phist_ctrl.sv =====
// Sequencer for the clearing sweep and the peak rescan, and the start bin register.
`default_nettype none

module phist_ctrl #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [phist_pkg::PIXEL_W-1:0]   cfg_wdata,
  input  wire logic                            clear_req,
  input  wire logic                            pipe_busy,
  input  wire logic [COUNT_BITS-1:0]           mem_rdata,
  output phist_pkg::phist_ctrl_t               stat,
  output logic      [$clog2(BINS)-1:0]         addr,
  output logic      [phist_pkg::PIXEL_W-1:0]   start_bin,
  output logic      [COUNT_BITS-1:0]           best
);

  localparam int IDX_W = $clog2(BINS);
  localparam int CMP_W = ((IDX_W > phist_pkg::PIXEL_W) ? IDX_W : phist_pkg::PIXEL_W) + 1;
  localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(BINS - 1);

  phist_pkg::phist_state_t state_r, state_nxt;
  logic [IDX_W-1:0]               addr_r, addr_nxt;
  logic [phist_pkg::PIXEL_W-1:0]  start_r, start_nxt;
  logic                           scan_req_r, scan_req_nxt;
  logic                           issue_r, issue_nxt;
  logic                           rdv_r, rdv_nxt;
  logic [COUNT_BITS-1:0]          best_r, best_nxt;
  logic [CMP_W-1:0]               start_ext;
  logic                           start_oob;

  assign start_ext = CMP_W'(start_r);
  assign start_oob = (start_ext >= CMP_W'(BINS));

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    start_nxt    = start_r;
    scan_req_nxt = scan_req_r;
    issue_nxt    = issue_r;
    rdv_nxt      = rdv_r;
    best_nxt     = best_r;
    stat         = '0;
    stat.busy    = (state_r != phist_pkg::ST_IDLE) || scan_req_r;

    if (cfg_we) begin
      start_nxt    = cfg_wdata;
      scan_req_nxt = 1'b1;
    end

    case (state_r)
      phist_pkg::ST_IDLE: begin
        if (clear_req) begin
          state_nxt = phist_pkg::ST_CLEAR;
          addr_nxt  = '0;
        end else if (scan_req_r && !cfg_we && !pipe_busy) begin
          // A start bin past the last bin scans nothing and loads a zero peak.
          state_nxt    = phist_pkg::ST_SCAN;
          scan_req_nxt = 1'b0;
          addr_nxt     = start_ext[IDX_W-1:0];
          issue_nxt    = !start_oob;
          rdv_nxt      = 1'b0;
          best_nxt     = '0;
        end
      end
      phist_pkg::ST_CLEAR: begin
        stat.mem_we = 1'b1;
        if (addr_r == LAST_BIN) begin
          state_nxt = phist_pkg::ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      phist_pkg::ST_SCAN: begin
        if (cfg_we) begin
          // A new start bin restarts the scan from the idle state.
          state_nxt = phist_pkg::ST_IDLE;
          issue_nxt = 1'b0;
          rdv_nxt   = 1'b0;
        end else begin
          if (issue_r) begin
            stat.mem_re = 1'b1;
            rdv_nxt     = 1'b1;
            if (addr_r == LAST_BIN) begin
              issue_nxt = 1'b0;
            end else begin
              addr_nxt = addr_r + 1'b1;
            end
          end else begin
            rdv_nxt = 1'b0;
          end
          if (rdv_r && (mem_rdata > best_r)) begin
            best_nxt = mem_rdata;
          end
          if (!issue_r && !rdv_r) begin
            stat.peak_load = 1'b1;
            state_nxt      = phist_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = phist_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // The store is swept to zero after reset.
      state_r    <= phist_pkg::ST_CLEAR;
      addr_r     <= '0;
      start_r    <= phist_pkg::PEAK_START_RESET;
      scan_req_r <= 1'b0;
      issue_r    <= 1'b0;
      rdv_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      addr_r     <= addr_nxt;
      start_r    <= start_nxt;
      scan_req_r <= scan_req_nxt;
      issue_r    <= issue_nxt;
      rdv_r      <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

  assign addr      = addr_r;
  assign start_bin = start_r;
  assign best      = best_r;

endmodule

`default_nettype wire

// ===== rtl/core/phist_outq.sv =====
// Three-word result queue that decouples the update stage from the output handshake.
`default_nettype none

module phist_outq #(
  parameter int WIDTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             wr_en,
  input  wire logic [WIDTH-1:0]                 wr_data,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [WIDTH-1:0]                 out_tdata,
  output logic      [phist_pkg::OUTQ_CNT_W-1:0] count
);

  localparam logic [phist_pkg::OUTQ_CNT_W-1:0] LAST_SLOT =
    phist_pkg::OUTQ_CNT_W'(phist_pkg::OUTQ_DEPTH - 1);

  logic [WIDTH-1:0]                 slot_r [phist_pkg::OUTQ_DEPTH];
  logic [phist_pkg::OUTQ_CNT_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [phist_pkg::OUTQ_CNT_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [phist_pkg::OUTQ_CNT_W-1:0] count_r, count_nxt;
  logic                             pop;

  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = slot_r[rd_ptr_r];
  assign count      = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pixel_histogram_with_peak.sv =====
// Histogram of pixel values with a tracked peak count.
//
// Each input word counts a pixel, reads a bin or clears all bins, and yields one
// output word with the bin count and the current peak. Counting and reading run
// at one word per clock while the output queue has room: the bin memory is read
// when the word is accepted and written back in the next cycle, with the last
// write forwarded to a following word that hits the same bin; each result passes
// from the update stage into a three-word output queue, which keeps input flowing
// while results wait. A clear returns its result at once and then sweeps the
// memory one bin per cycle, so no word is taken until the sweep ends; the same
// sweep runs after reset. Writing the peak start bin rescans the bins from the
// start bin upward, one read per cycle, and blocks input until the rescan ends.
`default_nettype none

module pixel_histogram_with_peak #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // opcode [1:0], pixel_value [9:2], bin_index [17:10], zero [23:18]
  input  wire logic [phist_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // bin_count [31:0], peak_count [63:32]
  output logic      [phist_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  wire logic                                cfg_wr_en,
  input  wire logic [phist_pkg::PIXEL_W-1:0]       cfg_wr_data
);

  localparam int IDX_W = $clog2(BINS);
  localparam int CMP_W = ((IDX_W > phist_pkg::PIXEL_W) ? IDX_W : phist_pkg::PIXEL_W) + 1;
  localparam int OUT_W = phist_pkg::OUT_W;

  // Input word fields
  logic [phist_pkg::OPCODE_W-1:0] in_op;
  logic [phist_pkg::PIXEL_W-1:0]  in_pix;
  logic [phist_pkg::PIXEL_W-1:0]  in_bin;
  logic [phist_pkg::PIXEL_W-1:0]  in_sel;
  logic [CMP_W-1:0]               in_sel_ext;
  logic                           in_accept;

  // Sequencer
  phist_pkg::phist_ctrl_t         ctrl_stat;
  logic [IDX_W-1:0]               ctrl_addr;
  logic [phist_pkg::PIXEL_W-1:0]  start_bin;
  logic [COUNT_BITS-1:0]          scan_best;
  logic                           clear_req;

  // Memory ports
  logic                           mem_we;
  logic [IDX_W-1:0]               mem_waddr;
  logic [COUNT_BITS-1:0]          mem_wdata;
  logic                           mem_re;
  logic [IDX_W-1:0]               mem_raddr;
  logic [COUNT_BITS-1:0]          mem_rdata;

  // Update stage
  logic                           s1_valid_r;
  logic [phist_pkg::OPCODE_W-1:0] s1_op_r;
  logic [IDX_W-1:0]               s1_addr_r;
  logic                           s1_inrange_r;
  logic                           s1_inpeak_r;
  logic                           fwd_valid_r;
  logic [IDX_W-1:0]               fwd_addr_r;
  logic [COUNT_BITS-1:0]          fwd_data_r;
  logic [COUNT_BITS-1:0]          cur_cnt;
  logic [COUNT_BITS-1:0]          inc_cnt;
  logic [COUNT_BITS-1:0]          res_cnt;
  logic                           s1_we;
  logic [COUNT_BITS-1:0]          peak_r, peak_nxt;

  // Output queue
  logic [OUT_W-1:0]                 res_cnt_out;
  logic [OUT_W-1:0]                 peak_out;
  logic [phist_pkg::OUTQ_CNT_W-1:0] q_count;
  logic [phist_pkg::OUTQ_CNT_W:0]   q_load;

  assign in_op      = in_tdata[1:0];
  assign in_pix     = in_tdata[9:2];
  assign in_bin     = in_tdata[17:10];
  assign in_sel     = (in_op == phist_pkg::OP_READ) ? in_bin : in_pix;
  assign in_sel_ext = CMP_W'(in_sel);

  // Results in flight plus queued results stay within the queue depth.
  assign q_load    = (phist_pkg::OUTQ_CNT_W + 1)'(q_count) +
                     (phist_pkg::OUTQ_CNT_W + 1)'(s1_valid_r);
  assign in_tready = !ctrl_stat.busy &&
                     (q_load < (phist_pkg::OUTQ_CNT_W + 1)'(phist_pkg::OUTQ_DEPTH));
  assign in_accept = in_tvalid && in_tready;
  assign clear_req = in_accept && (in_op == phist_pkg::OP_CLEAR);

  phist_ctrl #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_wr_en),
    .cfg_wdata (cfg_wr_data),
    .clear_req (clear_req),
    .pipe_busy (s1_valid_r),
    .mem_rdata (mem_rdata),
    .stat      (ctrl_stat),
    .addr      (ctrl_addr),
    .start_bin (start_bin),
    .best      (scan_best)
  );

  assign mem_re    = in_accept || ctrl_stat.mem_re;
  assign mem_raddr = ctrl_stat.mem_re ? ctrl_addr : in_sel_ext[IDX_W-1:0];
  assign mem_we    = s1_we || ctrl_stat.mem_we;
  assign mem_waddr = ctrl_stat.mem_we ? ctrl_addr : s1_addr_r;
  assign mem_wdata = ctrl_stat.mem_we ? '0 : inc_cnt;

  phist_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BINS)
  ) u_bins (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      peak_r      <= '0;
    end else begin
      s1_valid_r  <= in_accept;
      fwd_valid_r <= mem_we;
      peak_r      <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r      <= in_op;
    s1_addr_r    <= in_sel_ext[IDX_W-1:0];
    s1_inrange_r <= (in_sel_ext < CMP_W'(BINS));
    s1_inpeak_r  <= (in_pix >= start_bin);
    fwd_addr_r   <= mem_waddr;
    fwd_data_r   <= mem_wdata;
  end

  // The write made in the cycle of this word's read is not yet in the read data.
  assign cur_cnt = (fwd_valid_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r : mem_rdata;
  assign inc_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;

  always_comb begin
    s1_we    = 1'b0;
    res_cnt  = '0;
    peak_nxt = peak_r;
    if (ctrl_stat.peak_load) begin
      peak_nxt = scan_best;
    end
    if (s1_valid_r) begin
      case (s1_op_r)
        phist_pkg::OP_COUNT: begin
          if (s1_inrange_r) begin
            s1_we   = 1'b1;
            res_cnt = inc_cnt;
            if (s1_inpeak_r && (inc_cnt > peak_r)) begin
              peak_nxt = inc_cnt;
            end
          end
        end
        phist_pkg::OP_READ: begin
          if (s1_inrange_r) begin
            res_cnt = cur_cnt;
          end
        end
        phist_pkg::OP_CLEAR: begin
          peak_nxt = '0;
        end
        default: begin
          res_cnt = '0;
        end
      endcase
    end
  end

  if (COUNT_BITS >= OUT_W) begin : g_out_trunc
    assign res_cnt_out = res_cnt[OUT_W-1:0];
    assign peak_out    = peak_nxt[OUT_W-1:0];
  end else begin : g_out_ext
    assign res_cnt_out = {{(OUT_W - COUNT_BITS){1'b0}}, res_cnt};
    assign peak_out    = {{(OUT_W - COUNT_BITS){1'b0}}, peak_nxt};
  end

  phist_outq #(
    .WIDTH (phist_pkg::OUT_TDATA_W)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (s1_valid_r),
    .wr_data    ({peak_out, res_cnt_out}),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .count      (q_count)
  );

  // The update stage and the clearing sweep never share the write port.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_we && ctrl_stat.mem_we))
    else $error("update stage and clearing sweep write in the same cycle");

  // A scan read never collides with the read of an accepted word.
  a_one_reader: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_accept && ctrl_stat.mem_re))
    else $error("scan read and word read in the same cycle");

  // The queue always has room for a finished result.
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ((q_count != phist_pkg::OUTQ_CNT_W'(phist_pkg::OUTQ_DEPTH)) ||
                    (out_tvalid && out_tready)))
    else $error("result queue overflow");

  // The peak falls only through a clear or a rescan.
  a_peak_rise: assert property (@(posedge clk) disable iff (!rst_n)
    (peak_r < $past(peak_r)) |->
      ($past(ctrl_stat.peak_load) ||
       $past(s1_valid_r && (s1_op_r == phist_pkg::OP_CLEAR))))
    else $error("peak decreased without a clear or rescan");

endmodule

`default_nettype wire
